>>> rtl/wcb_pkg.sv
package wcb_pkg;

  localparam int unsigned DimW   = 13;
  localparam int unsigned CoordW = 16;
  localparam int unsigned PitchW = 15;
  localparam int unsigned BppW   = 3;
  localparam int unsigned ColorW = 32;
  localparam int unsigned OffW   = 26;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned ProdW  = DimW + PitchW;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegWindowLeft    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWindowTop     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegWindowColumns = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWindowRows    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegScreenColumns = 3'd4;
  localparam logic [CfgIdxW-1:0] RegScreenRows    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegLinePitch     = 3'd6;
  localparam logic [CfgIdxW-1:0] RegBytesPerPixel = 3'd7;

  // pixel depths that produce a write
  localparam logic [BppW-1:0] Bpp24 = 3'd3;
  localparam logic [BppW-1:0] Bpp32 = 3'd4;

  typedef struct packed {
    logic signed [CoordW-1:0] window_left;
    logic signed [CoordW-1:0] window_top;
    logic [DimW-1:0]          window_columns;
    logic [DimW-1:0]          window_rows;
    logic [DimW-1:0]          screen_columns;
    logic [DimW-1:0]          screen_rows;
    logic [PitchW-1:0]        line_pitch;
    logic [BppW-1:0]          bytes_per_pixel;
  } wcb_cfg_t;

  // visible pixel waiting for address generation
  typedef struct packed {
    logic [DimW-1:0]   sx;
    logic [DimW-1:0]   sy;
    logic [ColorW-1:0] color;
  } wcb_entry_t;

endpackage

>>> rtl/window_clip_blit_converter.sv
// Clipped window blit from 32-bit source pixels to a 32- or 24-bit screen. Source pixels
// enter in window raster order, one request per clock while the queue has room; column and
// row counters place each pixel in the window and wrap after window_columns x window_rows
// pixels, each capped at MAX_DIMENSION. Pixels that land on the screen (and only for a
// depth of 3 or 4 bytes) come out as a write with byte offset row * line_pitch + column *
// bytes_per_pixel, modulo 2^26. Clipping is done on entry and visible pixels wait in a
// four-entry queue; address generation behind it is a two-stage pipeline (pitch multiply,
// then add), one pixel per clock while output is taken. Write registers only while idle.
module window_clip_blit_converter
  import wcb_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                pixel_valid_i,
  output logic                pixel_ready_o,
  input  logic [ColorW-1:0]   pixel_color_i,
  output logic                result_valid_o,
  input  logic                result_ready_i,
  output logic [OffW-1:0]     dest_offset_o,
  output logic [ColorW-1:0]   write_data_o,
  output logic [BppW-1:0]     byte_count_o
);

  localparam int unsigned QueueDepth = 4;

  wcb_cfg_t   cfg_q, cfg_d;
  wcb_entry_t push_entry, pop_entry;
  logic       push, pop, q_full, q_valid, accept;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegWindowLeft:    cfg_d.window_left     = $signed(cfg_data_i);
        RegWindowTop:     cfg_d.window_top      = $signed(cfg_data_i);
        RegWindowColumns: cfg_d.window_columns  = cfg_data_i[DimW-1:0];
        RegWindowRows:    cfg_d.window_rows     = cfg_data_i[DimW-1:0];
        RegScreenColumns: cfg_d.screen_columns  = cfg_data_i[DimW-1:0];
        RegScreenRows:    cfg_d.screen_rows     = cfg_data_i[DimW-1:0];
        RegLinePitch:     cfg_d.line_pitch      = cfg_data_i[PitchW-1:0];
        RegBytesPerPixel: cfg_d.bytes_per_pixel = cfg_data_i[BppW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_left     <= '0;
      cfg_q.window_top      <= '0;
      cfg_q.window_columns  <= '0;
      cfg_q.window_rows     <= '0;
      cfg_q.screen_columns  <= DimW'(1024);
      cfg_q.screen_rows     <= DimW'(768);
      cfg_q.line_pitch      <= PitchW'(4096);
      cfg_q.bytes_per_pixel <= Bpp32;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign pixel_ready_o = !q_full;
  assign accept        = pixel_valid_i && pixel_ready_o;

  wcb_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .pixel_color_i,
    .push_o        (push),
    .entry_o       (push_entry)
  );

  wcb_fifo #(
    .WIDTH($bits(wcb_entry_t)),
    .DEPTH(QueueDepth)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_entry)
  );

  wcb_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i          (cfg_q),
    .entry_valid_i  (q_valid),
    .entry_i        (pop_entry),
    .pop_o          (pop),
    .result_valid_o,
    .result_ready_i,
    .dest_offset_o,
    .write_data_o,
    .byte_count_o
  );

endmodule

>>> rtl/wcb_fifo.sv
module wcb_fifo
  import wcb_pkg::*;
#(
  parameter int unsigned WIDTH = 58,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/wcb_front.sv
module wcb_front
  import wcb_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wcb_cfg_t          cfg_i,
  input  logic              accept_i,
  input  logic [ColorW-1:0] pixel_color_i,
  output logic              push_o,
  output wcb_entry_t        entry_o
);

  localparam int unsigned CntW = $clog2(MAX_DIMENSION);
  localparam int unsigned LimW = $clog2(MAX_DIMENSION + 1);
  localparam int unsigned CmpW = (LimW > DimW) ? LimW : DimW;
  localparam int unsigned PosW = CoordW + 2;
  localparam logic [CmpW-1:0] MaxDim = CmpW'(MAX_DIMENSION);

  logic [CntW-1:0] col_q, col_d, row_q, row_d;
  logic [CmpW-1:0] wc_ext, wr_ext;
  logic [LimW-1:0] w_lim, h_lim;
  logic            empty, restart, visible, depth_ok;
  logic [CntW-1:0] col_cur, row_cur;
  logic [LimW-1:0] col_inc, row_inc;
  logic signed [PosW-1:0] sx, sy, scols, srows;

  always_comb begin
    wc_ext  = CmpW'(cfg_i.window_columns);
    wr_ext  = CmpW'(cfg_i.window_rows);
    w_lim   = (wc_ext > MaxDim) ? LimW'(MaxDim) : LimW'(wc_ext);
    h_lim   = (wr_ext > MaxDim) ? LimW'(MaxDim) : LimW'(wr_ext);
    empty   = (w_lim == '0) || (h_lim == '0);
    // counters left outside a shrunk window start over
    restart = (LimW'(col_q) >= w_lim) || (LimW'(row_q) >= h_lim);
    col_cur = restart ? '0 : col_q;
    row_cur = restart ? '0 : row_q;

    sx    = PosW'(cfg_i.window_left) + $signed(PosW'(col_cur));
    sy    = PosW'(cfg_i.window_top) + $signed(PosW'(row_cur));
    scols = $signed(PosW'(cfg_i.screen_columns));
    srows = $signed(PosW'(cfg_i.screen_rows));
    depth_ok = (cfg_i.bytes_per_pixel == Bpp24) || (cfg_i.bytes_per_pixel == Bpp32);
    visible  = !empty && !sx[PosW-1] && !sy[PosW-1] && (sx < scols) && (sy < srows)
               && depth_ok;

    col_inc = LimW'(col_cur) + LimW'(1);
    row_inc = LimW'(row_cur) + LimW'(1);
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (empty) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= w_lim) begin
        col_d = '0;
        row_d = (row_inc >= h_lim) ? '0 : CntW'(row_inc);
      end else begin
        col_d = CntW'(col_inc);
        row_d = row_cur;
      end
    end
  end

  assign push_o        = accept_i && visible;
  assign entry_o.sx    = sx[DimW-1:0];
  assign entry_o.sy    = sy[DimW-1:0];
  assign entry_o.color = pixel_color_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> rtl/wcb_back.sv
module wcb_back
  import wcb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wcb_cfg_t          cfg_i,
  input  logic              entry_valid_i,
  input  wcb_entry_t        entry_i,
  output logic              pop_o,
  output logic              result_valid_o,
  input  logic              result_ready_i,
  output logic [OffW-1:0]   dest_offset_o,
  output logic [ColorW-1:0] write_data_o,
  output logic [BppW-1:0]   byte_count_o
);

  localparam int unsigned ColOffW = DimW + 2;

  logic                s1_valid_q, s1_valid_d;
  logic                out_valid_q, out_valid_d;
  logic                s1_en, s2_en;
  logic [ProdW-1:0]    prod_q, prod_d;
  logic [ColOffW-1:0]  col_off_q, col_off_d;
  logic [ColorW-1:0]   data_q, data_d;
  logic [BppW-1:0]     bc_q;
  logic [OffW-1:0]     off_q, off_d;
  logic [ColorW-1:0]   wdata_q;
  logic [BppW-1:0]     bcount_q;
  logic                is32;

  assign s2_en = !out_valid_q || result_ready_i;
  assign s1_en = !s1_valid_q || s2_en;
  assign pop_o = entry_valid_i && s1_en;
  assign is32  = (cfg_i.bytes_per_pixel == Bpp32);

  always_comb begin
    s1_valid_d  = s1_en ? entry_valid_i : s1_valid_q;
    out_valid_d = s2_en ? s1_valid_q : out_valid_q;
    prod_d      = ProdW'(entry_i.sy) * ProdW'(cfg_i.line_pitch);
    // column times 3 or 4 without a multiplier
    col_off_d   = is32 ? {entry_i.sx, 2'b00}
                       : ColOffW'({entry_i.sx, 1'b0}) + ColOffW'(entry_i.sx);
    data_d      = is32 ? entry_i.color : {8'h00, entry_i.color[23:0]};
    off_d       = prod_q[OffW-1:0] + OffW'(col_off_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_q    <= prod_d;
      col_off_q <= col_off_d;
      data_q    <= data_d;
      bc_q      <= cfg_i.bytes_per_pixel;
    end
    if (s2_en && s1_valid_q) begin
      off_q    <= off_d;
      wdata_q  <= data_q;
      bcount_q <= bc_q;
    end
  end

  assign result_valid_o = out_valid_q;
  assign dest_offset_o  = off_q;
  assign write_data_o   = wdata_q;
  assign byte_count_o   = bcount_q;

endmodule
